// ===== hw/rtl/b64e_pkg.sv =====
// Shared types, constants and the alphabet lookup for the Base64 stream encoder.
`default_nettype none
package b64e_pkg;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [6:0] PAD_IDX  = 7'h40;
    localparam logic [4:0] LINE_GROUPS = 5'd19;

    // Group sizes carried with a group command
    localparam logic [1:0] NB_ONE   = 2'd1;
    localparam logic [1:0] NB_TWO   = 2'd2;
    localparam logic [1:0] NB_THREE = 2'd3;

    // Character slots within one group: CR, LF, then four symbols
    localparam logic [2:0] SLOT_CR   = 3'd0;
    localparam logic [2:0] SLOT_LF   = 3'd1;
    localparam logic [2:0] SLOT_S0   = 3'd2;
    localparam logic [2:0] SLOT_S1   = 3'd3;
    localparam logic [2:0] SLOT_S2   = 3'd4;
    localparam logic [2:0] SLOT_S3   = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_item;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nbytes;
        logic       crlf;
    } t_grp_cmd;

    // Index 0..63 maps to the standard alphabet, anything above to '='
    function automatic logic [7:0] b64_char(input logic [6:0] idx);
        logic [7:0] c;
        if (idx > 7'd63) begin
            c = 8'h3D;
        end else if (idx < 7'd26) begin
            c = 8'h41 + {1'b0, idx};
        end else if (idx < 7'd52) begin
            c = 8'h61 + {1'b0, idx} - 8'd26;
        end else if (idx < 7'd62) begin
            c = 8'h30 + {1'b0, idx} - 8'd52;
        end else if (idx == 7'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/b64e_front.sv =====
// Front end: collects input bytes into 3-byte groups and issues group commands.
`default_nettype none
module b64e_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_push,
    input  wire b64e_pkg::t_in_item i_data,
    input  wire logic              i_cmd_full,
    output logic                   o_full,
    output logic                   o_cmd_push,
    output b64e_pkg::t_grp_cmd     o_cmd
);

    logic        r_line_breaks;
    logic [15:0] r_held;
    logic [15:0] n_held;
    logic [1:0]  r_pos;
    logic [1:0]  n_pos;
    logic [4:0]  r_gol;
    logic [4:0]  n_gol;

    logic [1:0]  pos_eff;
    logic        accept;
    logic        emit;
    logic        line_due;

    assign o_full  = i_cmd_full;
    assign accept  = i_push && !i_cmd_full;
    assign pos_eff = (r_pos == 2'd3) ? 2'd2 : r_pos;
    assign emit    = (pos_eff == 2'd2) || i_data.last_byte;
    assign line_due = (r_gol >= b64e_pkg::LINE_GROUPS);

    assign o_cmd_push = accept && emit;

    always_comb begin
        o_cmd.crlf = line_due && r_line_breaks;
        case (pos_eff)
            2'd0: begin
                o_cmd.b0     = i_data.data_byte;
                o_cmd.b1     = 8'd0;
                o_cmd.b2     = 8'd0;
                o_cmd.nbytes = b64e_pkg::NB_ONE;
            end
            2'd1: begin
                o_cmd.b0     = r_held[15:8];
                o_cmd.b1     = i_data.data_byte;
                o_cmd.b2     = 8'd0;
                o_cmd.nbytes = b64e_pkg::NB_TWO;
            end
            default: begin
                o_cmd.b0     = r_held[15:8];
                o_cmd.b1     = r_held[7:0];
                o_cmd.b2     = i_data.data_byte;
                o_cmd.nbytes = b64e_pkg::NB_THREE;
            end
        endcase
    end

    always_comb begin
        n_held = r_held;
        n_pos  = r_pos;
        n_gol  = r_gol;
        if (accept) begin
            if (emit) begin
                n_held = 16'd0;
                n_pos  = 2'd0;
                if (i_data.last_byte) begin
                    n_gol = 5'd0;
                end else if (line_due) begin
                    n_gol = 5'd1;
                end else begin
                    n_gol = r_gol + 5'd1;
                end
            end else if (pos_eff == 2'd0) begin
                n_held = {i_data.data_byte, 8'd0};
                n_pos  = 2'd1;
            end else begin
                n_held = {r_held[15:8], i_data.data_byte};
                n_pos  = 2'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_breaks <= 1'b0;
            r_held        <= 16'd0;
            r_pos         <= 2'd0;
            r_gol         <= 5'd0;
        end else begin
            if (i_cfg_we) begin
                r_line_breaks <= i_cfg_wdata;
            end
            r_held <= n_held;
            r_pos  <= n_pos;
            r_gol  <= n_gol;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/b64e_cmd_fifo.sv =====
// Small queue of group commands between the front and back ends.
`default_nettype none
module b64e_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire b64e_pkg::t_grp_cmd i_cmd,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output b64e_pkg::t_grp_cmd      o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64e_pkg::t_grp_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/b64e_back.sv =====
// Back end: commands to characters in an output register, one per cycle if not stalled.
`default_nettype none
module b64e_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_empty,
    input  wire b64e_pkg::t_grp_cmd i_cmd,
    output logic                    o_cmd_pop,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output b64e_pkg::t_out_item     o_data
);

    logic [2:0]  r_cnt;     // characters already sent from the head command
    logic        r_valid;
    b64e_pkg::t_out_item r_out;

    logic [2:0]  slot;
    logic        load;
    logic        slot_last;
    logic [6:0]  sym_idx;
    b64e_pkg::t_out_item nxt;

    assign o_empty = !r_valid;
    assign o_data  = r_out;
    assign load    = !i_cmd_empty && (!r_valid || i_pop);
    assign slot    = i_cmd.crlf ? r_cnt : r_cnt + 3'd2;
    assign slot_last = (slot == b64e_pkg::SLOT_S3);
    assign o_cmd_pop = load && slot_last;

    always_comb begin
        case (slot)
            b64e_pkg::SLOT_S0: sym_idx = {1'b0, i_cmd.b0[7:2]};
            b64e_pkg::SLOT_S1: sym_idx = {1'b0, i_cmd.b0[1:0], i_cmd.b1[7:4]};
            b64e_pkg::SLOT_S2: sym_idx = (i_cmd.nbytes == b64e_pkg::NB_ONE) ?
                                         b64e_pkg::PAD_IDX :
                                         {1'b0, i_cmd.b1[3:0], i_cmd.b2[7:6]};
            default:           sym_idx = (i_cmd.nbytes != b64e_pkg::NB_THREE) ?
                                         b64e_pkg::PAD_IDX :
                                         {1'b0, i_cmd.b2[5:0]};
        endcase
    end

    always_comb begin
        nxt.last_char = slot_last;
        case (slot)
            b64e_pkg::SLOT_CR: nxt.out_char = b64e_pkg::CHAR_CR;
            b64e_pkg::SLOT_LF: nxt.out_char = b64e_pkg::CHAR_LF;
            default:           nxt.out_char = b64e_pkg::b64_char(sym_idx);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_cnt   <= slot_last ? 3'd0 : r_cnt + 3'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/base64_stream_encoder.sv =====
// Base64 stream encoder with optional 76-character line breaks.
//
// Input queue side: one raw byte per beat with a last-byte flag, taken when
// push is high and full is low. Output queue side: one character per beat
// on o_data while empty is low, taken when pop is high. i_cfg_we with
// i_cfg_wdata sets line breaks (CR LF after every 19 groups, 76 characters).
// The front end accepts one byte per cycle while the command queue is not
// full and packs 3-byte groups; each finished group (or the last byte of a
// message) becomes a command in a CMD_DEPTH-entry queue. The back end
// sends 4 characters per group, 6 when CR LF goes first, at one character
// per cycle while the receiver pops; the output character rate sets throughput.
// The byte that completes a group writes its command into the queue, and
// the first character loads from there into the output register when free.
// When the receiver stalls the output register holds its character, the
// command queue fills and full rises; bytes that only join a group are
// still taken until then. Synchronous reset empties the queue and output,
// clears the held group and line count and turns line breaks off.
`default_nettype none
module base64_stream_encoder #(
    parameter int CMD_DEPTH = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_wdata,
    input  wire logic                push,
    output logic                     full,
    input  wire b64e_pkg::t_in_item  i_data,
    output logic                     empty,
    input  wire logic                pop,
    output b64e_pkg::t_out_item      o_data
);

    logic               cmd_push;
    logic               cmd_pop;
    logic               cmd_full;
    logic               cmd_empty;
    b64e_pkg::t_grp_cmd cmd_in;
    b64e_pkg::t_grp_cmd cmd_out;

    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_data      (i_data),
        .i_cmd_full  (cmd_full),
        .o_full      (full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    b64e_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_full  (cmd_full),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_data      (o_data)
    );

endmodule
`default_nettype wire

// ===== bench/tb_base64_stream_encoder.sv =====
// Self-checking testbench for the Base64 stream encoder: directed and random bytes, random idling.
module tb_base64_stream_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {RX_STREAM, RX_RANDOM, RX_SPARSE} t_rx_mode;

    // Expected character stream built from every accepted byte
    class b64_char_checker;
        string alphabet =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";
        logic        line_breaks;
        logic [15:0] held_bytes;
        logic [1:0]  group_fill;
        logic [4:0]  groups_on_line;
        b64e_pkg::t_out_item expected_chars[$];
        int          mismatches;

        function new();
            line_breaks    = 1'b0;
            held_bytes     = '0;
            group_fill     = '0;
            groups_on_line = '0;
            mismatches     = 0;
        endfunction

        function void set_line_breaks(logic v);
            line_breaks = v;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void queue_char(logic [7:0] c, logic fin);
            b64e_pkg::t_out_item ch;
            ch.out_char  = c;
            ch.last_char = fin;
            expected_chars.push_back(ch);
        endfunction

        function void emit_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                 int count);
            int sx[4];
            // line count wraps even with breaks off, so lines stay aligned
            if (groups_on_line >= b64e_pkg::LINE_GROUPS) begin
                if (line_breaks) begin
                    queue_char(b64e_pkg::CHAR_CR, 1'b0);
                    queue_char(b64e_pkg::CHAR_LF, 1'b0);
                end
                groups_on_line = '0;
            end
            sx[0] = int'(b0[7:2]);
            sx[1] = int'({b0[1:0], b1[7:4]});
            sx[2] = (count < 2) ? int'(b64e_pkg::PAD_IDX) : int'({b1[3:0], b2[7:6]});
            sx[3] = (count < 3) ? int'(b64e_pkg::PAD_IDX) : int'(b2[5:0]);
            for (int k = 0; k < 4; k++) begin
                queue_char(alphabet[sx[k]], k == 3);
            end
            groups_on_line = groups_on_line + 5'd1;
        endfunction

        function void encode_byte(b64e_pkg::t_in_item it);
            logic [7:0] h0;
            logic [7:0] h1;
            h0 = held_bytes[15:8];
            h1 = held_bytes[7:0];
            if (group_fill == 2'd0) begin
                if (!it.last_byte) begin
                    held_bytes = {it.data_byte, 8'h00};
                    group_fill = 2'd1;
                    return;
                end
                emit_group(it.data_byte, 8'h00, 8'h00, 1);
            end else if (group_fill == 2'd1) begin
                if (!it.last_byte) begin
                    held_bytes = {h0, it.data_byte};
                    group_fill = 2'd2;
                    return;
                end
                emit_group(h0, it.data_byte, 8'h00, 2);
            end else begin
                emit_group(h0, h1, it.data_byte, 3);
            end
            held_bytes = '0;
            group_fill = '0;
            if (it.last_byte) begin
                groups_on_line = '0;
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 50) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endtask

        task check_char(b64e_pkg::t_out_item got);
            b64e_pkg::t_out_item want;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected char 0x%02h last %0b",
                                 got.out_char, got.last_char));
                return;
            end
            want = expected_chars.pop_front();
            if (got.out_char !== want.out_char) begin
                report($sformatf("out_char 0x%02h, want 0x%02h",
                                 got.out_char, want.out_char));
            end
            if (got.last_char !== want.last_char) begin
                report($sformatf("last_char %0b, want %0b on char 0x%02h",
                                 got.last_char, want.last_char, want.out_char));
            end
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      push = 1'b0;
    logic      full;
    b64e_pkg::t_in_item  i_data = '0;
    logic      empty;
    logic      pop = 1'b0;
    b64e_pkg::t_out_item o_data;

    b64_char_checker sb = new();

    int       cycles = 0;
    int       burst_left = 0;
    int       hold_left = 0;
    int       hold_reqs = 0;
    int       hold_taken = 0;
    int       mode_left = 0;
    t_rx_mode rx_mode = RX_STREAM;

    base64_stream_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_data      (i_data),
        .empty       (empty),
        .pop         (pop),
        .o_data      (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: checks each popped beat, stalls on its own pattern
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_char(o_data);
        end
        if (hold_taken != hold_reqs) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = hold_reqs;
        end
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 2));
            mode_left = $urandom_range(16, 80);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STREAM: begin
                    pop <= 1'b1;
                end
                RX_RANDOM: begin
                    pop <= 1'($urandom_range(0, 1));
                end
                default: begin
                    pop <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        b64e_pkg::t_in_item it;
        it.data_byte = b;
        it.last_byte = lst;
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
        end
        push   <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (full);
        sb.encode_byte(it);
        burst_left--;
    endtask

    task automatic drain_and_settle();
        push <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        // a byte that only joins a group may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_breaks(input logic v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_line_breaks(v);
        i_cfg_we    <= 1'b0;
    endtask

    // Random messages; the phase may stop mid-message and the next one resumes it
    task automatic random_phase(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(58, 130)
                                              : $urandom_range(1, 12);
            for (int k = 0; k < len && sent < n_items; k++) begin
                send_byte(8'($urandom_range(0, 255)), k == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_line_breaks(1'b1);

        // one- to five-byte messages at the extremes, '+' and '/'
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'h12, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h6E, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        drain_and_settle();

        hold_reqs++;
        random_phase(100);
        drain_and_settle();
        write_line_breaks(1'b0);
        random_phase(100);
        drain_and_settle();
        write_line_breaks(1'b1);
        hold_reqs++;
        random_phase(80);
        drain_and_settle();
        write_line_breaks(1'b0);
        random_phase(70);
        drain_and_settle();
        repeat (20) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
